// ===== src/ppu_pkg.sv =====
package ppu_pkg;

  typedef struct packed {
    logic        kind;
    logic [2:0]  life_init;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic [31:0] color_rgba;
    logic [15:0] particle_size;
    logic [15:0] step_time;
    logic [31:0] cam_x;
    logic [31:0] cam_y;
    logic [31:0] cam_z;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [15:0] size_out;
    logic [31:0] color_out;
    logic [63:0] dist_sq;
    logic        last;
  } out_t;

  localparam logic       KIND_SPAWN  = 1'b0;

  localparam logic [2:0] ST_SPAWNED  = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_DRAWN    = 3'd2;
  localparam logic [2:0] ST_EXPIRED  = 3'd3;
  localparam logic [2:0] ST_NO_LIVE  = 3'd4;

  // 9.81 in Q16.16
  localparam logic [19:0] GRAVITY_Q16 = 20'd642908;

  // saturate a 34-bit signed value to the signed 32-bit range
  function automatic logic [31:0] sat32(logic [33:0] v);
    logic [31:0] r;
    if ((v[33:31] == 3'b000) || (v[33:31] == 3'b111)) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

endpackage

// ===== src/ppu_mul.sv =====
module ppu_mul (
  input  logic               clk_i,
  input  logic signed [33:0] a_i,
  input  logic signed [33:0] b_i,
  output logic signed [67:0] p_o
);

  logic signed [67:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== src/ppu_seq.sv =====
module ppu_seq #(
  parameter int unsigned POOL_SLOTS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ppu_pkg::in_t   in_data_i,
  output logic           rec_valid_o,
  input  logic           rec_ready_i,
  output ppu_pkg::out_t  rec_o
);

  localparam int unsigned SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned EW = $clog2(3 * POOL_SLOTS);
  localparam int unsigned CW = $clog2(POOL_SLOTS + 1);
  localparam logic [SW-1:0] SLOT_MAX = SW'(POOL_SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_WR, S_DV, S_DV2, S_SCAN, S_LIFE,
    S_MV, S_ADD, S_SQ, S_ACC, S_OUT
  } state_e;

  state_e               state_q, state_d;
  ppu_pkg::in_t         in_q, in_d;
  logic [SW-1:0]        slot_q, slot_d, search_q, search_d, cnt_q, cnt_d;
  logic [1:0]           axis_q, axis_d;
  logic [EW-1:0]        ent_q, ent_d;
  logic [POOL_SLOTS-1:0] live_q, live_d;
  logic [CW-1:0]        live_cnt_q, live_cnt_d, left_q, left_d;
  logic [19:0]          dv_q, dv_d;
  logic [2:0][31:0]     pn_q, pn_d;
  logic [63:0]          dist_q, dist_d;
  logic [2:0]           status_q, status_d;
  logic                 last_q, last_d;

  // storage
  logic [23:0] life_mem  [POOL_SLOTS];
  logic [31:0] pos_mem   [3*POOL_SLOTS];
  logic [31:0] vel_mem   [3*POOL_SLOTS];
  logic [15:0] size_mem  [POOL_SLOTS];
  logic [31:0] color_mem [POOL_SLOTS];
  logic [23:0] life_rd_q;
  logic [31:0] pos_rd_q, vel_rd_q, color_rd_q;
  logic [15:0] size_rd_q;

  logic        life_we, pos_we, vel_we, sc_we;
  logic [23:0] life_wd;
  logic [31:0] pos_wd, vel_wd;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;

  logic [EW-1:0] ent_base;
  logic [SW-1:0] slot_next;
  logic [33:0]   sum34, vy34, diff34;
  logic [31:0]   pn, cam_sel;
  logic [64:0]   dsum;

  ppu_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign ent_base  = EW'({slot_q, 1'b0}) + EW'(slot_q);
  assign slot_next = (slot_q == SLOT_MAX) ? '0 : slot_q + SW'(1);

  always_comb begin
    case (axis_q)
      2'd0:    cam_sel = in_q.cam_x;
      2'd1:    cam_sel = in_q.cam_y;
      default: cam_sel = in_q.cam_z;
    endcase
  end

  assign sum34  = {{2{pos_rd_q[31]}}, pos_rd_q} + 34'(mul_p[49:16]);
  assign pn     = ppu_pkg::sat32(sum34);
  assign vy34   = {{2{vel_rd_q[31]}}, vel_rd_q} - {14'b0, dv_q};
  assign diff34 = {{2{pn_q[axis_q][31]}}, pn_q[axis_q]} - {{2{cam_sel[31]}}, cam_sel};
  assign dsum   = {1'b0, dist_q} + {1'b0, mul_p[63:0]};

  always_comb begin
    state_d    = state_q;
    in_d       = in_q;
    slot_d     = slot_q;
    search_d   = search_q;
    cnt_d      = cnt_q;
    axis_d     = axis_q;
    ent_d      = ent_q;
    live_d     = live_q;
    live_cnt_d = live_cnt_q;
    left_d     = left_q;
    dv_d       = dv_q;
    pn_d       = pn_q;
    dist_d     = dist_q;
    status_d   = status_q;
    last_d     = last_q;
    life_we    = 1'b0;
    life_wd    = '0;
    pos_we     = 1'b0;
    pos_wd     = '0;
    vel_we     = 1'b0;
    vel_wd     = '0;
    sc_we      = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    in_ready_o  = 1'b0;
    rec_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          in_d = in_data_i;
          if (in_data_i.kind == ppu_pkg::KIND_SPAWN) begin
            slot_d  = search_q;
            cnt_d   = '0;
            state_d = S_SRCH;
          end else begin
            slot_d  = '0;
            left_d  = live_cnt_q;
            state_d = S_DV;
          end
        end
      end
      S_SRCH: begin
        if (!live_q[slot_q]) begin
          life_we  = 1'b1;
          life_wd  = {5'b0, in_q.life_init, 16'b0};
          sc_we    = 1'b1;
          search_d = slot_q;
          if (in_q.life_init != 3'd0) begin
            live_d[slot_q] = 1'b1;
            live_cnt_d     = live_cnt_q + CW'(1);
          end
          axis_d  = '0;
          ent_d   = ent_base;
          state_d = S_WR;
        end else if (cnt_q == SLOT_MAX) begin
          status_d = ppu_pkg::ST_FULL;
          last_d   = 1'b1;
          state_d  = S_OUT;
        end else begin
          cnt_d  = cnt_q + SW'(1);
          slot_d = slot_next;
        end
      end
      S_WR: begin
        pos_we = 1'b1;
        vel_we = 1'b1;
        case (axis_q)
          2'd0:    vel_wd = in_q.vel_x;
          2'd1:    vel_wd = in_q.vel_y;
          default: vel_wd = in_q.vel_z;
        endcase
        if (axis_q == 2'd2) begin
          status_d = ppu_pkg::ST_SPAWNED;
          last_d   = 1'b1;
          state_d  = S_OUT;
        end else begin
          axis_d = axis_q + 2'd1;
          ent_d  = ent_q + EW'(1);
        end
      end
      S_DV: begin
        mul_a   = 34'(ppu_pkg::GRAVITY_Q16);
        mul_b   = 34'(in_q.step_time);
        state_d = S_DV2;
      end
      S_DV2: begin
        dv_d = mul_p[36:17];
        if (left_q == '0) begin
          status_d = ppu_pkg::ST_NO_LIVE;
          last_d   = 1'b1;
          state_d  = S_OUT;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (live_q[slot_q]) begin
          ent_d   = ent_base + EW'(1);
          state_d = S_LIFE;
        end else if (slot_q == SLOT_MAX) begin
          state_d = S_IDLE;
        end else begin
          slot_d = slot_next;
        end
      end
      S_LIFE: begin
        last_d = (left_q == CW'(1));
        left_d = left_q - CW'(1);
        dist_d = '0;
        if ({8'b0, in_q.step_time} >= life_rd_q) begin
          live_d[slot_q] = 1'b0;
          live_cnt_d     = live_cnt_q - CW'(1);
          status_d       = ppu_pkg::ST_EXPIRED;
          state_d        = S_OUT;
        end else begin
          life_we = 1'b1;
          life_wd = life_rd_q - {8'b0, in_q.step_time};
          vel_we  = 1'b1;
          vel_wd  = ppu_pkg::sat32(vy34);
          axis_d  = '0;
          ent_d   = ent_q - EW'(1);
          state_d = S_MV;
        end
      end
      S_MV: begin
        mul_a   = {{2{vel_rd_q[31]}}, vel_rd_q};
        mul_b   = 34'(in_q.step_time);
        state_d = S_ADD;
      end
      S_ADD: begin
        pos_we         = 1'b1;
        pos_wd         = pn;
        pn_d[axis_q]   = pn;
        state_d        = S_SQ;
      end
      S_SQ: begin
        mul_a   = diff34;
        mul_b   = diff34;
        state_d = S_ACC;
      end
      S_ACC: begin
        dist_d = dsum[64] ? '1 : dsum[63:0];
        if (axis_q == 2'd2) begin
          status_d = ppu_pkg::ST_DRAWN;
          state_d  = S_OUT;
        end else begin
          axis_d  = axis_q + 2'd1;
          ent_d   = ent_q + EW'(1);
          state_d = S_MV;
        end
      end
      S_OUT: begin
        rec_valid_o = 1'b1;
        if (rec_ready_i) begin
          if (last_q) begin
            state_d = S_IDLE;
          end else begin
            slot_d  = slot_next;
            state_d = S_SCAN;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    rec_o        = '0;
    rec_o.status = status_q;
    rec_o.last   = last_q;
    case (status_q)
      ppu_pkg::ST_SPAWNED: begin
        rec_o.slot      = 6'(slot_q);
        rec_o.size_out  = in_q.particle_size;
        rec_o.color_out = in_q.color_rgba;
      end
      ppu_pkg::ST_DRAWN: begin
        rec_o.slot      = 6'(slot_q);
        rec_o.pos_x     = pn_q[0];
        rec_o.pos_y     = pn_q[1];
        rec_o.pos_z     = pn_q[2];
        rec_o.size_out  = size_rd_q;
        rec_o.color_out = color_rd_q;
        rec_o.dist_sq   = dist_q;
      end
      ppu_pkg::ST_EXPIRED: rec_o.slot = 6'(slot_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (life_we) life_mem[slot_q] <= life_wd;
    if (pos_we) pos_mem[ent_q] <= pos_wd;
    if (vel_we) vel_mem[ent_q] <= vel_wd;
    if (sc_we) begin
      size_mem[slot_q]  <= in_q.particle_size;
      color_mem[slot_q] <= in_q.color_rgba;
    end
    life_rd_q  <= life_mem[slot_q];
    size_rd_q  <= size_mem[slot_q];
    color_rd_q <= color_mem[slot_q];
    pos_rd_q   <= pos_mem[ent_d];
    vel_rd_q   <= vel_mem[ent_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      slot_q     <= '0;
      search_q   <= '0;
      cnt_q      <= '0;
      axis_q     <= '0;
      ent_q      <= '0;
      live_q     <= '0;
      live_cnt_q <= '0;
      left_q     <= '0;
      status_q   <= ppu_pkg::ST_SPAWNED;
      last_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      slot_q     <= slot_d;
      search_q   <= search_d;
      cnt_q      <= cnt_d;
      axis_q     <= axis_d;
      ent_q      <= ent_d;
      live_q     <= live_d;
      live_cnt_q <= live_cnt_d;
      left_q     <= left_d;
      status_q   <= status_d;
      last_q     <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    dv_q   <= dv_d;
    pn_q   <= pn_d;
    dist_q <= dist_d;
  end

`ifndef SYNTHESIS
  a_live_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_cnt_q == CW'($countones(live_q)))
    else $error("live count out of step with live bits");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_o && rec_ready_i && rec_o.last |=> in_ready_o)
    else $error("not idle after final word");

  a_life_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LIFE |-> live_q[slot_q])
    else $error("aging a free slot");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !rec_valid_o)
    else $error("ready while a word is pending");
`endif

endmodule

// ===== src/particle_pool_update.sv =====
// Spawn: accept, search up to POOL_SLOTS slots for a free one, write its three axes, then the word.
// Tick: accept, gravity setup, then a scan that skips free slots and ages each live slot
// (one shared multiplier does gravity, three position steps and three squares).
// Items are handled one at a time; results leave through one output register.
// Reset clears the live bits, live count and search start; all slots are free.
// Position, velocity, size and color stores are not reset.
module particle_pool_update #(
  parameter int unsigned POOL_SLOTS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ppu_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ppu_pkg::out_t out_data_o
);

  logic          rec_valid, rec_ready;
  ppu_pkg::out_t rec;
  ppu_pkg::out_t out_q;
  logic          out_valid_q;

  ppu_seq #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .rec_valid_o (rec_valid),
    .rec_ready_i (rec_ready),
    .rec_o       (rec)
  );

  assign rec_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rec_ready) begin
      out_valid_q <= rec_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_ready && rec_valid) begin
      out_q <= rec;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
